// ===== hw/rtl/nan_aware_moving_average_assert.svh =====
// Assertion macros used by the property checker file (nam_checker).
`ifndef NAN_AWARE_MOVING_AVERAGE_ASSERT_SVH
`define NAN_AWARE_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define NAM_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication under synchronous active-low reset.
`define NAM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/nam_pkg.sv =====
package nam_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 32;
  localparam int SUM_BITS    = 40;
  localparam int COUNT_BITS  = 9;
  localparam int WLEN_BITS   = 9;
  localparam int WLEN_RESET  = 20;
  localparam int MIN_DIV     = 4;

  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int ENTRY_W    = SAMPLE_BITS + 1;
  localparam int ITER_W     = $clog2(SUM_BITS);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = '0;

  typedef enum logic [1:0] {
    WIN_IDLE,
    WIN_RMW,
    WIN_SEND
  } win_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic                   ok;
    logic [SAMPLE_BITS-1:0] samp;
  } win_entry_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic                  go;
  } div_req_t;

endpackage

// ===== hw/rtl/nam_if.sv =====
interface nam_in_if import nam_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sample_valid;
  logic                          series_start;

  modport source (output valid, sample, sample_valid, series_start, input ready);
  modport sink   (input valid, sample, sample_valid, series_start, output ready);
endinterface

interface nam_out_if import nam_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic                          mean_valid;

  modport source (output valid, mean, mean_valid, input ready);
  modport sink   (input valid, mean, mean_valid, output ready);
endinterface

// ===== hw/rtl/nam_ram.sv =====
module nam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/nam_window.sv =====
module nam_window import nam_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [WLEN_BITS-1:0] window_len,
  nam_in_if.sink               in_ch,
  output logic                 req_valid,
  input  logic                 req_ready,
  output div_req_t             req
);

  localparam int W1    = (LEN_W > WLEN_BITS) ? LEN_W : WLEN_BITS;
  localparam int CMP_W = (W1 > COUNT_BITS) ? W1 : COUNT_BITS;
  localparam int EXT_W = SUM_BITS - SAMPLE_BITS;

  win_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]      wp_r, wp_use_r;
  logic [LEN_W-1:0]       seen_r, seen_use_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [COUNT_BITS-1:0]  cnt_r;
  logic [SAMPLE_BITS-1:0] samp_r;
  logic                   sv_r, start_r, leave_r;
  div_req_t               req_r;

  logic [CMP_W-1:0]   wl_x, len_x, minp_x;
  logic [LEN_W-1:0]   len;
  logic               in_fire;
  logic [ADDR_W-1:0]  wp_base;
  logic [LEN_W-1:0]   seen_base;
  logic [LEN_W:0]     wp_x, idx_x;
  logic [ADDR_W-1:0]  raddr;
  logic [ENTRY_W-1:0] rdata;
  win_entry_t         rd;
  logic               drop;
  logic [SUM_BITS-1:0]   sum_base, add_v, sub_v, sum_nxt;
  logic [COUNT_BITS-1:0] cnt_base, cnt_nxt;
  logic                  go;

  // effective window length and minimum number of periods
  always_comb begin
    wl_x = CMP_W'(window_len);
    if (wl_x == '0) begin
      len_x = CMP_W'(1);
    end else if (wl_x > CMP_W'(MAX_WINDOW)) begin
      len_x = CMP_W'(MAX_WINDOW);
    end else begin
      len_x = wl_x;
    end
    minp_x = CMP_W'(len_x / MIN_DIV);
    if (minp_x == '0) begin
      minp_x = CMP_W'(1);
    end
    len = len_x[LEN_W-1:0];
  end

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign wp_base   = in_ch.series_start ? '0 : wp_r;
  assign seen_base = in_ch.series_start ? '0 : seen_r;

  // slot of the sample leaving the window
  always_comb begin
    wp_x = (LEN_W + 1)'(wp_base);
    if (wp_x >= (LEN_W + 1)'(len)) begin
      idx_x = wp_x - (LEN_W + 1)'(len);
    end else begin
      idx_x = wp_x + (LEN_W + 1)'(MAX_WINDOW) - (LEN_W + 1)'(len);
    end
    raddr = idx_x[ADDR_W-1:0];
  end

  nam_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (state_r == WIN_RMW),
    .waddr (wp_use_r),
    .wdata ({sv_r, samp_r}),
    .re    (in_fire),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read-modify-write of sum and count
  always_comb begin
    rd       = win_entry_t'(rdata);
    drop     = leave_r && rd.ok;
    sum_base = start_r ? '0 : sum_r;
    cnt_base = start_r ? '0 : cnt_r;
    add_v    = sv_r ? {{EXT_W{samp_r[SAMPLE_BITS-1]}}, samp_r} : '0;
    sub_v    = drop ? {{EXT_W{rd.samp[SAMPLE_BITS-1]}}, rd.samp} : '0;
    sum_nxt  = sum_base + add_v - sub_v;
    cnt_nxt  = cnt_base + COUNT_BITS'(sv_r) - COUNT_BITS'(drop);
    go       = (cnt_nxt != '0) && (CMP_W'(cnt_nxt) >= minp_x);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      WIN_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = WIN_RMW;
        end
      end
      WIN_RMW:  state_nxt = WIN_SEND;
      WIN_SEND: begin
        if (req_ready) begin
          state_nxt = WIN_IDLE;
        end
      end
      default:  state_nxt = WIN_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    req_valid   = 1'b0;
    case (state_r)
      WIN_IDLE: in_ch.ready = 1'b1;
      WIN_SEND: req_valid   = 1'b1;
      default: begin
        in_ch.ready = 1'b0;
        req_valid   = 1'b0;
      end
    endcase
  end

  assign req = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= WIN_IDLE;
      wp_r    <= '0;
      seen_r  <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == WIN_RMW) begin
        wp_r   <= (wp_use_r == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_use_r + 1'b1;
        seen_r <= (seen_use_r < LEN_W'(MAX_WINDOW)) ? seen_use_r + 1'b1 : seen_use_r;
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      samp_r     <= in_ch.sample;
      sv_r       <= in_ch.sample_valid;
      start_r    <= in_ch.series_start;
      wp_use_r   <= wp_base;
      seen_use_r <= seen_base;
      leave_r    <= (seen_base >= len);
    end
    if (state_r == WIN_RMW) begin
      req_r <= '{sum: sum_nxt, count: cnt_nxt, go: go};
    end
  end

endmodule

// ===== hw/rtl/nam_divider.sv =====
module nam_divider import nam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_ready,
  input  div_req_t req,
  nam_out_if.source out_ch
);

  localparam logic [ITER_W-1:0]   ITER_LAST = ITER_W'(SUM_BITS - 1);
  localparam logic [SUM_BITS-1:0] HI_MAG    = SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  div_state_t state_r, state_nxt;

  logic [SUM_BITS-1:0]    quo_r;
  logic [COUNT_BITS-1:0]  rem_r, den_r;
  logic [ITER_W-1:0]      iter_r;
  logic                   neg_r, go_r, mv_r;
  logic [SAMPLE_BITS-1:0] mean_r;

  logic [COUNT_BITS:0]  trial, diff;
  logic                 ge;
  logic [SUM_BITS-1:0]  mag, quo_neg;
  logic                 sum_neg;

  assign sum_neg = req.sum[SUM_BITS-1];
  assign mag     = sum_neg ? (~req.sum + 1'b1) : req.sum;
  assign trial   = {rem_r, quo_r[SUM_BITS-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign diff    = trial - {1'b0, den_r};
  assign quo_neg = ~quo_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DIV_IDLE: begin
        if (req_valid) begin
          state_nxt = req.go ? DIV_RUN : DIV_FIX;
        end
      end
      DIV_RUN: begin
        if (iter_r == ITER_LAST) begin
          state_nxt = DIV_FIX;
        end
      end
      DIV_FIX:  state_nxt = DIV_DONE;
      DIV_DONE: begin
        if (out_ch.ready) begin
          state_nxt = DIV_IDLE;
        end
      end
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      DIV_IDLE: req_ready    = 1'b1;
      DIV_DONE: out_ch.valid = 1'b1;
      default: begin
        req_ready    = 1'b0;
        out_ch.valid = 1'b0;
      end
    endcase
  end

  assign out_ch.mean       = mean_r;
  assign out_ch.mean_valid = mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      DIV_IDLE: begin
        if (req_valid) begin
          quo_r  <= req.go ? mag : '0;
          neg_r  <= req.go && sum_neg;
          go_r   <= req.go;
          den_r  <= req.count;
          rem_r  <= '0;
          iter_r <= '0;
        end
      end
      DIV_RUN: begin
        // one restoring step per cycle, quotient bits shift in at the bottom
        rem_r  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        quo_r  <= {quo_r[SUM_BITS-2:0], ge};
        iter_r <= iter_r + 1'b1;
      end
      DIV_FIX: begin
        mv_r <= go_r;
        if (!neg_r) begin
          mean_r <= (quo_r > HI_MAG) ? SAT_HI : quo_r[SAMPLE_BITS-1:0];
        end else begin
          mean_r <= (quo_r > HI_MAG + 1'b1) ? SAT_LO : quo_neg[SAMPLE_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/nan_aware_moving_average.sv =====
// Channel | Dir | Handshake           | Payload
// in_ch   | in  | valid/ready         | sample, sample_valid, series_start
// out_ch  | out | valid/ready         | mean, mean_valid
// APB     | in  | psel/penable/pready | window_len at byte address 0
//
// Pacing: with the sink ready, the restoring divider, at one quotient bit per
//   cycle, sets the rate; it takes no new item until its result has gone.
//   Items whose mean is not valid skip the divide steps.
// Path: accept, window read-modify-write, handoff, divide, fix-up, from input
//   transfer to result transfer; a mean that is not valid skips the divide.
// Reset: synchronous, active low; window_len returns to 20. No store clearing:
//   an entry is only read after it has been written in the current series.
// Stalls: a held output freezes the divider; the window stage still takes
//   one more item and parks its partial result until the divider frees up.
module nan_aware_moving_average import nam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  nam_in_if.sink                in_ch,
  nam_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WLEN_BITS-1:0] wlen_r;
  logic                 reg_hit;
  logic                 req_valid, req_ready;
  div_req_t             req;

  // single register; word index taken from the upper address bits
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LEN);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? CFG_DATA_W'(wlen_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_BITS'(WLEN_RESET);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      wlen_r <= pwdata[WLEN_BITS-1:0];
    end
  end

  // window store, running sum and count
  nam_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .window_len (wlen_r),
    .in_ch      (in_ch),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req)
  );

  // sum / count, truncated toward zero and saturated; holds the result
  nam_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_ch    (out_ch)
  );

endmodule

// ===== hw/rtl/nam_checker.sv =====
`include "nan_aware_moving_average_assert.svh"

module nam_checker import nam_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_mean,
  input logic                   out_mean_valid
);

  // a mean that is not valid reads as zero
  `NAM_ASSERT_SAME(a_nan_mean_zero, clk, rst_n, out_valid && !out_mean_valid, out_mean == '0)
  // one item in the window stage at a time
  `NAM_ASSERT_NEXT(a_in_single, clk, rst_n, in_valid && in_ready, !in_ready)
  // after a result transfer the next result still needs a fix-up, so valid drops
  `NAM_ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid && out_ready, !out_valid)
  `NAM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mean) && $stable(out_mean_valid))

endmodule

bind nan_aware_moving_average nam_checker u_nam_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_mean       (out_ch.mean),
  .out_mean_valid (out_ch.mean_valid)
);

// ===== dv/nam_mean_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the config bus, predicts each mean from the input
// transfers and compares it with the result transfers in order.
module nam_mean_checker import nam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  nam_in_if                     in_ch,
  nam_out_if                    out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending
);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] mean;
    logic                          mean_valid;
  } mean_t;

  localparam longint MEAN_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint MEAN_MIN = -MEAN_MAX - 1;

  logic signed [SAMPLE_BITS-1:0] win_samp [MAX_WINDOW];
  logic                          win_ok   [MAX_WINDOW];
  logic [WLEN_BITS-1:0]          win_len;
  logic [SUM_BITS-1:0]           acc;
  logic [COUNT_BITS-1:0]         n_valid;
  int unsigned                   wr_ptr;
  int unsigned                   fill;
  mean_t                         pending_means [$];

  // Advances the window by one sample and returns the mean it produces.
  function automatic mean_t next_mean(logic signed [SAMPLE_BITS-1:0] samp, logic samp_ok,
                                      logic restart);
    int unsigned len;
    int unsigned min_cnt;
    int unsigned idx;
    longint      total;
    longint      divisor;
    longint      quot;
    mean_t       res;
    len = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len);
    min_cnt = len / MIN_DIV;
    if (min_cnt < 1) min_cnt = 1;
    if (restart) begin
      acc = '0;
      n_valid = '0;
      wr_ptr = 0;
      fill = 0;
    end
    if (samp_ok) begin
      acc = acc + SUM_BITS'(samp);
      n_valid = n_valid + 1'b1;
    end
    // oldest sample drops out once the window has filled
    if (fill >= len) begin
      idx = (wr_ptr + MAX_WINDOW - len) % MAX_WINDOW;
      if (win_ok[idx]) begin
        acc = acc - SUM_BITS'(win_samp[idx]);
        n_valid = n_valid - 1'b1;
      end
    end
    win_samp[wr_ptr] = samp;
    win_ok[wr_ptr] = samp_ok;
    wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
    if (fill < MAX_WINDOW) fill++;
    res.mean = '0;
    res.mean_valid = 1'b0;
    if (n_valid != 0 && n_valid >= min_cnt) begin
      total = $signed(acc);
      divisor = n_valid;
      quot = total / divisor;
      if (quot > MEAN_MAX) quot = MEAN_MAX;
      if (quot < MEAN_MIN) quot = MEAN_MIN;
      res.mean = SAMPLE_BITS'(quot);
      res.mean_valid = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    mean_t want;
    if (!rst_n) begin
      win_len = WLEN_BITS'(WLEN_RESET);
      acc = '0;
      n_valid = '0;
      wr_ptr = 0;
      fill = 0;
      fail_count = 0;
      pending_means.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LEN)
        win_len = pwdata[WLEN_BITS-1:0];
      if (in_ch.valid && in_ch.ready)
        pending_means = {pending_means, next_mean(in_ch.sample, in_ch.sample_valid,
                                                  in_ch.series_start)};
      if (out_ch.valid && out_ch.ready) begin
        if (pending_means.size() == 0) begin
          $error("result transfer with no mean expected");
          fail_count++;
        end else begin
          want = pending_means.pop_front();
          if (out_ch.mean !== want.mean) begin
            $error("mean: expected %0d, actual %0d", want.mean, out_ch.mean);
            fail_count++;
          end
          if (out_ch.mean_valid !== want.mean_valid) begin
            $error("mean_valid: expected %0d, actual %0d", want.mean_valid,
                   out_ch.mean_valid);
            fail_count++;
          end
        end
      end
    end
    pending = pending_means.size();
  end

endmodule

// ===== dv/tb_nan_aware_moving_average.sv =====
`timescale 1ns / 100ps

module tb_nan_aware_moving_average;
  import nam_pkg::*;

  // wait after the last result before touching window_len: covers one full
  // divide plus the handoff stages, with margin
  localparam int SETTLE_CYCLES = 64;

  // window_len values for the random phases; 0 and above-256 values check the
  // clamping, and phases that keep the old series check a mid-series change
  localparam int unsigned WIN_PLAN [14] = '{1, 0, 2, 3, 4, 5, 8, 13, 20, 64, 256, 511, 7, 300};

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_ONE = 32'sh0001_0000;  // 1.0 in Q15.16

  // how often a series marks samples as NaN
  typedef enum logic [1:0] {
    MIX_DENSE,
    MIX_HALF,
    MIX_SPARSE,
    MIX_MOSTLY
  } nan_mix_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  // per-phase switches for the random gaps on each side
  bit                    in_idle_on;
  bit                    out_idle_on;
  int unsigned           cur_len;      // window length the block applies now
  int unsigned           series_left;  // items left in the current series
  nan_mix_t              mix;

  nam_in_if  in_ch ();
  nam_out_if out_ch ();

  nan_aware_moving_average u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nam_mean_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run (~1650 items)
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: before each transfer ready may be held low (only with out_idle_on
  // set), then it stays high until a transfer happens. ready is read at the edge before
  // any update, so a transfer is valid && ready at that edge.
  initial begin
    int unsigned hold;
    forever begin
      hold = out_idle_on ? $urandom_range(0, 3) : 0;
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // One input transfer. valid stays high after the transfer so a back-to-back
  // item does not see valid dropped and raised in the same step.
  task automatic push_item(input logic signed [SAMPLE_BITS-1:0] samp, input logic samp_ok,
                           input logic restart);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= samp;
    in_ch.sample_valid <= samp_ok;
    in_ch.series_start <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, let every predicted mean arrive, then let the pipe go quiet.
  // The first edge lets the checker book the last transfer before pending is read.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of window_len: setup phase, then access until pready.
  task automatic write_window(input int unsigned len);
    int unsigned raw;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_LEN, 2'b00};
    pwdata  <= CFG_DATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    raw = len % 512;
    cur_len = (raw == 0) ? 1 : (raw > MAX_WINDOW) ? MAX_WINDOW : raw;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom;
      4:          return SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
      5:          return $urandom_range(0, 1) ? S_MAX : S_MIN;
      6:          return SAMPLE_BITS'((int'($urandom_range(0, 64)) - 32) * 65536);
      default:    return SAMPLE_BITS'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  function automatic logic pick_valid(nan_mix_t m);
    case (m)
      MIX_DENSE:  return $urandom_range(0, 15) != 0;
      MIX_HALF:   return $urandom_range(0, 1) != 0;
      MIX_SPARSE: return $urandom_range(0, 7) == 0;
      default:    return $urandom_range(0, 3) != 0;
    endcase
  endfunction

  // Mostly whole series of random length (up to about two windows), with the
  // odd restart thrown in mid-series. Half the phases keep the series that was
  // running, so the new window_len applies to the history already gathered.
  task automatic random_phase(input int unsigned n_items);
    logic restart;
    in_idle_on  = $urandom_range(0, 3) != 0;
    out_idle_on = $urandom_range(0, 3) != 0;
    if ($urandom_range(0, 1) != 0) series_left = 0;
    repeat (n_items) begin
      restart = 1'b0;
      if (series_left == 0 || $urandom_range(0, 63) == 0) begin
        restart = 1'b1;
        series_left = $urandom_range(1, 2 * cur_len + 8);
        mix = nan_mix_t'($urandom_range(0, 3));
      end
      series_left--;
      push_item(pick_sample(), pick_valid(mix), restart);
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.sample       <= '0;
    in_ch.sample_valid <= 1'b0;
    in_ch.series_start <= 1'b0;
    cur_len     = WLEN_RESET;
    series_left = 0;
    mix         = MIX_DENSE;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset window (20): min periods is 5, so the mean turns valid only on the
    // fifth valid sample; a NaN in between does not count
    push_item(S_MAX, 1'b1, 1'b1);
    push_item(S_MIN, 1'b1, 1'b0);
    push_item(32'sh0001_8000, 1'b1, 1'b0);
    push_item(-S_ONE, 1'b0, 1'b0);
    push_item(-3, 1'b1, 1'b0);
    push_item(S_ONE, 1'b1, 1'b0);

    // window of 2: extremes, truncation toward zero, NaN-only windows
    write_window(2);
    push_item(S_MAX, 1'b1, 1'b1);
    push_item(S_MAX, 1'b1, 1'b0);
    push_item(S_MIN, 1'b1, 1'b0);      // (max + min) / 2 truncates to 0
    push_item(S_MIN, 1'b1, 1'b0);
    push_item(-3, 1'b1, 1'b0);
    push_item(32'sh1234_5678, 1'b0, 1'b0);
    push_item(32'sh7654_3210, 1'b0, 1'b0);  // -3 leaves: zero count, mean 0
    push_item(S_MIN, 1'b0, 1'b1);      // restart on a NaN: zero count
    push_item(-1, 1'b1, 1'b1);
    push_item(0, 1'b1, 1'b0);          // -1 / 2 truncates to 0
    push_item(1, 1'b1, 1'b0);

    // window_len 0 acts as 1
    write_window(0);
    push_item(-S_ONE, 1'b1, 1'b1);
    push_item(0, 1'b0, 1'b0);
    push_item(7, 1'b1, 1'b0);

    foreach (WIN_PLAN[k]) begin
      write_window(WIN_PLAN[k]);
      random_phase(WIN_PLAN[k] >= 128 ? 280 : 70);
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
